// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/chct_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chct_pkg
// Types and constants of the canonical Huffman code table.
// ============================================================================
package chct_pkg;

    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = 8;
    localparam int SYM_FW   = 8;
    localparam int RUN_W    = CODE_W + 1;
    localparam int ENTRY_W  = CODE_W + LEN_W;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_APPEND = 2'd2;
    localparam logic [1:0] REQ_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [LEN_W-1:0]  length_index;
        logic [CNT_W-1:0]  count;
        logic [SYM_FW-1:0] symbol;
    } chct_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_length;
        logic [1:0]        status;
    } chct_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic advance;
        logic finish;
    } chct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_skip;
    } chct_stat_t;

endpackage

// ===== rtl/chct_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chct_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module chct_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chct_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chct_ctrl
// Controller: takes a request, steps the length search, then finishes it.
// ============================================================================
module chct_ctrl
    import chct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  chct_stat_t stat,
    output logic       busy,
    output chct_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // One empty or full length is passed per cycle.
                if (stat.need_skip)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_EXEC);

endmodule

// ===== rtl/chct_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chct_dp
// Datapath: count table, valid bits, code counters, code store, result.
// ============================================================================
module chct_dp
    import chct_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  chct_req_t  req,
    input  chct_cmd_t  cmd,
    output chct_stat_t stat,
    output chct_rsp_t  rsp,
    output logic       done
);

    localparam int SYM_W    = $clog2(NUM_SYMBOLS);
    localparam int LIDX_W   = $clog2(MAX_CODE_LEN);
    localparam int LOADED_W = $clog2(NUM_SYMBOLS + 1);

    chct_req_t               req_reg;
    logic [CNT_W-1:0]        count_reg [MAX_CODE_LEN];
    logic [CNT_W-1:0]        count_next [MAX_CODE_LEN];
    logic [NUM_SYMBOLS-1:0]  valid_reg;
    logic [NUM_SYMBOLS-1:0]  valid_next;
    logic [RUN_W-1:0]        run_reg;
    logic [RUN_W-1:0]        run_next;
    logic [LEN_W-1:0]        cur_reg;
    logic [LEN_W-1:0]        cur_next;
    logic [CNT_W-1:0]        used_reg;
    logic [CNT_W-1:0]        used_next;
    logic [LOADED_W-1:0]     loaded_reg;
    logic [LOADED_W-1:0]     loaded_next;
    chct_rsp_t               rsp_reg;
    chct_rsp_t               rsp_next;
    logic                    done_reg;

    logic                    sym_oob;
    logic [SYM_W-1:0]        sym_idx;
    logic                    cur_in_range;
    logic [LIDX_W-1:0]       cnt_idx;
    logic                    len_ok;
    logic [LIDX_W-1:0]       set_idx;
    logic                    table_full;
    logic                    no_space;
    logic                    ram_we;
    logic [SYM_W-1:0]        ram_addr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    assign sym_oob      = {1'b0, req_reg.symbol} >= (SYM_FW + 1)'(NUM_SYMBOLS);
    assign sym_idx      = req_reg.symbol[SYM_W-1:0];
    assign cur_in_range = cur_reg <= LEN_W'(MAX_CODE_LEN);
    assign cnt_idx      = LIDX_W'(cur_reg - LEN_W'(1));
    assign len_ok       = (req_reg.length_index != '0) &&
                          (req_reg.length_index <= LEN_W'(MAX_CODE_LEN));
    assign set_idx      = LIDX_W'(req_reg.length_index - LEN_W'(1));
    assign table_full   = !cur_in_range || (loaded_reg >= LOADED_W'(NUM_SYMBOLS));
    assign no_space     = (run_reg >> cur_reg) != '0;

    assign stat.need_skip = (req_reg.req_type == REQ_APPEND) && !sym_oob &&
                            cur_in_range && (used_reg >= count_reg[cnt_idx]);

    // A lookup reads the store at the accept edge so the data is ready next cycle.
    assign ram_addr  = cmd.capture ? req.symbol[SYM_W-1:0] : sym_idx;
    assign ram_wdata = {cur_reg, run_reg[CODE_W-1:0]};
    assign ram_we    = cmd.finish && (req_reg.req_type == REQ_APPEND) && !sym_oob &&
                       !table_full && !no_space && !valid_reg[sym_idx];

    chct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_chct_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next  = count_reg;
        valid_next  = valid_reg;
        run_next    = run_reg;
        cur_next    = cur_reg;
        used_next   = used_reg;
        loaded_next = loaded_reg;
        rsp_next    = '0;

        if (cmd.advance)
        begin
            run_next  = run_reg << 1;
            cur_next  = cur_reg + LEN_W'(1);
            used_next = '0;
        end

        if (cmd.finish)
        begin
            case (req_reg.req_type)
                REQ_CLEAR:
                begin
                    for (int i = 0; i < MAX_CODE_LEN; i++)
                    begin
                        count_next[i] = '0;
                    end
                    valid_next  = '0;
                    run_next    = '0;
                    cur_next    = LEN_W'(1);
                    used_next   = '0;
                    loaded_next = '0;
                end
                REQ_SET:
                begin
                    if (len_ok)
                    begin
                        count_next[set_idx] = req_reg.count;
                    end
                end
                REQ_APPEND:
                begin
                    if (sym_oob)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else if (table_full)
                    begin
                        rsp_next.status = ST_TOO_MANY;
                    end
                    else if (no_space)
                    begin
                        rsp_next.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        // A repeated symbol keeps its first stored code.
                        valid_next[sym_idx]  = 1'b1;
                        run_next             = run_reg + RUN_W'(1);
                        used_next            = used_reg + CNT_W'(1);
                        loaded_next          = loaded_reg + LOADED_W'(1);
                        rsp_next.code        = run_reg[CODE_W-1:0];
                        rsp_next.code_length = cur_reg;
                        rsp_next.status      = ST_OK;
                    end
                end
                REQ_LOOKUP:
                begin
                    if (sym_oob || !valid_reg[sym_idx])
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        rsp_next.code        = ram_rdata[CODE_W-1:0];
                        rsp_next.code_length = ram_rdata[ENTRY_W-1:CODE_W];
                        rsp_next.status      = ST_OK;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CODE_LEN; i++)
            begin
                count_reg[i] <= '0;
            end
            valid_reg  <= '0;
            run_reg    <= '0;
            cur_reg    <= LEN_W'(1);
            used_reg   <= '0;
            loaded_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            run_reg    <= run_next;
            cur_reg    <= cur_next;
            used_reg   <= used_next;
            loaded_reg <= loaded_next;
            done_reg   <= cmd.finish;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

// ===== rtl/canonical_huffman_code_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// canonical_huffman_code_table
// JPEG-style canonical Huffman table: clear, set counts, append, look up.
// ============================================================================
//
//   Channel   Ports              Direction  Transfer
//   request   start, busy, req   in         start high while busy is low
//   result    done, rsp          out        done high for one cycle
//
// A request transaction accepted at one edge is worked on from the next cycle
// on; its result is shown, with done high, in the cycle after the one that
// finishes it. Clear, set count and lookup take no length steps; an append
// first passes each code length that is empty or already full, as the length
// search moves one length per cycle. A lookup reads the code store at the
// accept edge, so the store's registered read is ready in time. busy falls
// while the result is shown, so the next transaction can be accepted in that
// same cycle. Reset clears the counts, valid bits and code counters at once;
// the code store itself needs no clearing pass. Results cannot be stalled.
//
module canonical_huffman_code_table
    import chct_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  chct_req_t req,
    output logic      done,
    output chct_rsp_t rsp
);

    chct_cmd_t  cmd;
    chct_stat_t stat;

    // The controller sequences each transaction: capture, length steps, finish.
    chct_ctrl u_chct_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath holds the table state and registers the result.
    chct_dp #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_chct_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp),
        .done  (done)
    );

endmodule

// ===== rtl/chct_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chct_checker
// Port-level checks of the canonical Huffman code table.
// ============================================================================
`include "assert_macros.svh"

module chct_checker
    import chct_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input chct_rsp_t rsp
);

    logic accepted;
    logic failed;
    logic good_code;

    assign accepted  = start && !busy;
    assign failed    = done && (rsp.status != ST_OK);
    assign good_code = (rsp.code_length == '0) ||
                       ((rsp.code >> rsp.code_length) == '0);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accepted, busy)
    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, done, !busy)
    `ASSERT_IMPL(a_done_after_work, clk, rst_n, done, $past(busy))
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, failed, rsp.code == '0 && rsp.code_length == '0)
    `ASSERT_IMPL(a_code_fits, clk, rst_n, done, good_code)

endmodule

bind canonical_huffman_code_table chct_checker u_chct_checker (.*);

// ===== bench/tb_canonical_huffman_code_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_canonical_huffman_code_table
// Self-checking bench for the canonical Huffman code table. A directed
// opening walks through the corner cases. Random table-building sessions
// follow: clear, load counts, then append and look up with bursty request
// timing. A scoreboard class predicts every result and checks it in order.
// ============================================================================
module tb_canonical_huffman_code_table;
    import chct_pkg::*;

    localparam int MAX_LEN      = 16;
    localparam int TABLE_SIZE   = 256;
    localparam int ITEM_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the table state and turns every
    // accepted request transaction into the result the block must produce.
    // Results are checked strictly in order, one per request.
    // ------------------------------------------------------------------------
    class huffman_table_scoreboard;
        logic [CNT_W-1:0]   len_count [MAX_LEN];
        logic [ENTRY_W-1:0] code_word [TABLE_SIZE];
        bit                 sym_valid [TABLE_SIZE];
        // Set once a symbol's store entry has been written since reset.
        bit                 sym_written [TABLE_SIZE];
        logic [RUN_W-1:0]   next_code;
        logic [LEN_W-1:0]   cur_len;
        logic [CNT_W-1:0]   used_here;
        logic [8:0]         loaded;
        chct_rsp_t          expected_rsp_q [$];
        int unsigned        error_count;

        function new();
            foreach (sym_written[i]) sym_written[i] = 1'b0;
            error_count = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (len_count[i]) len_count[i] = '0;
            foreach (sym_valid[i]) sym_valid[i] = 1'b0;
            next_code = '0;
            cur_len   = 5'd1;
            used_here = '0;
            loaded    = '0;
        endfunction

        // Applies one request to the table copy and returns its result.
        function chct_rsp_t apply_request(chct_req_t q);
            chct_rsp_t r;
            r = '0;
            r.status = ST_OK;
            case (q.req_type)
                REQ_CLEAR: clear_table();
                REQ_SET:
                begin
                    if (q.length_index >= 1 && q.length_index <= MAX_LEN)
                        len_count[q.length_index - 1] = q.count;
                end
                REQ_APPEND:
                begin
                    // Move past every length whose declared count is used up.
                    while (cur_len <= MAX_LEN && used_here >= len_count[cur_len - 1])
                    begin
                        next_code = next_code << 1;
                        cur_len   = cur_len + LEN_W'(1);
                        used_here = '0;
                    end
                    if (cur_len > MAX_LEN || loaded >= TABLE_SIZE)
                        r.status = ST_TOO_MANY;
                    else if ((next_code >> cur_len) != 0)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        r.code        = next_code[CODE_W-1:0];
                        r.code_length = cur_len;
                        // A duplicate keeps the code it was first given.
                        if (!sym_valid[q.symbol])
                        begin
                            code_word[q.symbol]   = {cur_len, next_code[CODE_W-1:0]};
                            sym_valid[q.symbol]   = 1'b1;
                            sym_written[q.symbol] = 1'b1;
                        end
                        next_code = next_code + RUN_W'(1);
                        used_here = used_here + CNT_W'(1);
                        loaded    = loaded + 9'd1;
                    end
                end
                default:
                begin
                    if (!sym_valid[q.symbol])
                        r.status = ST_NOT_FOUND;
                    else
                        {r.code_length, r.code} = code_word[q.symbol];
                end
            endcase
            return r;
        endfunction

        function void note_request(chct_req_t q);
            expected_rsp_q.push_back(apply_request(q));
        endfunction

        function void check_response(chct_rsp_t got);
            chct_rsp_t want;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result code=%h length=%0d status=%0d",
                         $time, got.code, got.code_length, got.status);
                error_count++;
                return;
            end
            want = expected_rsp_q.pop_front();
            if (got.code !== want.code)
            begin
                $display("%0t: code expected %h actual %h", $time, want.code, got.code);
                error_count++;
            end
            if (got.code_length !== want.code_length)
            begin
                $display("%0t: code_length expected %0d actual %0d",
                         $time, want.code_length, got.code_length);
                error_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    chct_req_t req;
    chct_rsp_t rsp;

    huffman_table_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned items_sent;
    int unsigned burst_left;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    canonical_huffman_code_table #(
        .MAX_CODE_LEN (MAX_LEN),
        .NUM_SYMBOLS  (TABLE_SIZE)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the block's
    // registered outputs still show their pre-edge values. A request is noted
    // before a result is checked; a result never belongs to a request that is
    // accepted at the same edge, so the order of the two does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req);
            if (done)
                sb.check_response(rsp);
        end
    end

    // A hung block must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver. It is always entered at a falling edge. The sender works in
    // bursts: between bursts start drops for a random number of cycles, which
    // lands on every phase of the block's work, since the previous transaction
    // may still be in flight. Within a burst start simply stays high.
    // ------------------------------------------------------------------------
    task automatic send_request(input chct_req_t r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // Now and then a long burst gives a stretch with no idling.
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        start <= 1'b1;
        req   <= r;
        // The transaction goes through at the first edge that sees busy low.
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (!(r.req_type == REQ_SET && (r.length_index == 0 || r.length_index > MAX_LEN)))
            items_sent++;
        @(negedge clk);
    endtask

    // Fields that a request type does not use carry random bits.
    task automatic issue(input logic [1:0] kind, input int len, input int cnt, input int sym);
        chct_req_t   r;
        logic [31:0] rnd;
        rnd = $urandom;
        r = rnd[$bits(chct_req_t)-1:0];
        r.req_type = kind;
        if (kind == REQ_SET)
        begin
            r.length_index = LEN_W'(len);
            r.count        = CNT_W'(cnt);
        end
        if (kind == REQ_APPEND || kind == REQ_LOOKUP)
            r.symbol = SYM_FW'(sym);
        send_request(r);
    endtask

    // Lookups only go to symbols whose store entry has been written at some
    // point; a cleared entry still gives a not-found answer.
    task automatic lookup_written(input int hint);
        int sym;
        int tries;
        sym = hint;
        tries = 0;
        while (!sb.sym_written[sym] && tries < 16)
        begin
            sym = $urandom_range(0, TABLE_SIZE - 1);
            tries++;
        end
        if (sb.sym_written[sym])
            issue(REQ_LOOKUP, 0, 0, sym);
    endtask

    // ------------------------------------------------------------------------
    // Random sessions.
    // ------------------------------------------------------------------------

    // Loads a random count profile and appends symbols through it, with
    // lookups, duplicates and the odd count change mixed in.
    task automatic table_session();
        int free_codes;
        int cnt;
        int total;
        int sym;
        int ep_syms [$];
        bit taken [TABLE_SIZE];
        total = 0;
        free_codes = 2;
        foreach (taken[i]) taken[i] = 1'b0;
        issue(REQ_CLEAR, 0, 0, 0);
        for (int len = 1; len <= MAX_LEN; len++)
        begin
            if ($urandom_range(0, 1) == 0)
                cnt = 0;
            else
                cnt = $urandom_range(0, (free_codes < 5) ? free_codes : 5);
            // Occasionally declare more codes than the length can hold.
            if ($urandom_range(0, 24) == 0 && free_codes < 255)
                cnt = free_codes + 1;
            if (cnt != 0 || $urandom_range(0, 4) == 0)
                issue(REQ_SET, len, cnt, 0);
            total += cnt;
            free_codes = (cnt > free_codes) ? 0 : (free_codes - cnt) * 2;
            if (free_codes > 4096)
                free_codes = 4096;
        end
        total += $urandom_range(0, 2);
        for (int i = 0; i < total; i++)
        begin
            if (ep_syms.size() != 0 && $urandom_range(0, 19) == 0)
                sym = ep_syms[$urandom_range(0, ep_syms.size() - 1)];
            else
            begin
                sym = $urandom_range(0, TABLE_SIZE - 1);
                while (taken[sym])
                    sym = $urandom_range(0, TABLE_SIZE - 1);
            end
            taken[sym] = 1'b1;
            ep_syms.push_back(sym);
            issue(REQ_APPEND, 0, 0, sym);
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(0, 9) < 7)
                    lookup_written(ep_syms[$urandom_range(0, ep_syms.size() - 1)]);
                else
                    lookup_written($urandom_range(0, TABLE_SIZE - 1));
            end
            if ($urandom_range(0, 29) == 0)
                issue(REQ_SET, $urandom_range(1, MAX_LEN), $urandom_range(0, 10), 0);
        end
    endtask

    // Fills the table to its full size and one past it.
    task automatic full_table_session();
        issue(REQ_CLEAR, 0, 0, 0);
        issue(REQ_SET, 9, 255, 0);
        issue(REQ_SET, 10, 255, 0);
        for (int i = 0; i <= TABLE_SIZE; i++)
        begin
            issue(REQ_APPEND, 0, 0, i % TABLE_SIZE);
            if ($urandom_range(0, 7) == 0)
                lookup_written(i % TABLE_SIZE);
        end
    endtask

    // Unstructured requests, ignored count writes among them.
    task automatic noise_session();
        int pick;
        repeat ($urandom_range(10, 30))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                issue(REQ_CLEAR, 0, 0, 0);
            else if (pick < 40)
                issue(REQ_SET, $urandom_range(0, 31), $urandom_range(0, 255), 0);
            else if (pick < 70)
                issue(REQ_APPEND, 0, 0, $urandom_range(0, TABLE_SIZE - 1));
            else
                lookup_written($urandom_range(0, TABLE_SIZE - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int roll;
        sb          = new();
        items_sent  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed opening. Lengths 1 and 3 are declared, length 2 is empty.
        issue(REQ_CLEAR, 0, 0, 0);
        issue(REQ_SET, 0, 255, 0);          // length zero is ignored
        issue(REQ_SET, 17, 7, 0);           // length above the maximum is ignored
        issue(REQ_SET, 31, 0, 0);
        issue(REQ_SET, 1, 1, 0);
        issue(REQ_SET, 3, 2, 0);
        issue(REQ_APPEND, 0, 0, 0);         // code 0, one bit
        issue(REQ_APPEND, 0, 0, 255);       // skips the empty length two
        issue(REQ_APPEND, 0, 0, 0);         // duplicate gets a code, store keeps first
        issue(REQ_LOOKUP, 0, 0, 0);
        issue(REQ_LOOKUP, 0, 0, 255);
        issue(REQ_APPEND, 0, 0, 7);         // every length filled: too many symbols
        issue(REQ_SET, 16, 255, 0);
        issue(REQ_CLEAR, 0, 0, 0);
        issue(REQ_LOOKUP, 0, 0, 0);         // cleared entry is not found
        // A single length cannot hold more codes than its width allows.
        issue(REQ_SET, 1, 255, 0);
        issue(REQ_APPEND, 0, 0, 8'h55);
        issue(REQ_APPEND, 0, 0, 8'hAA);
        issue(REQ_APPEND, 0, 0, 8'h0F);     // code space exhausted
        // The longest code: fifteen empty lengths are passed on one append.
        issue(REQ_CLEAR, 0, 0, 0);
        issue(REQ_SET, 16, 1, 0);
        issue(REQ_APPEND, 0, 0, 8'h80);
        issue(REQ_LOOKUP, 0, 0, 8'h80);

        // Random part: mostly well-formed sessions, some noise, and now and
        // then a session that runs the table past its full size.
        while (items_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                full_table_session();
            else if (roll < 85)
                table_session();
            else
                noise_session();
        end
        start <= 1'b0;

        // Drain, then give a stray late result the chance to show up.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
